FILE: rtl/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and constants of the round-robin scheduler.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int MaxJobsDef = 32;
  localparam int IdW        = 8;
  localparam int ArrW       = 16;
  localparam int BurstW     = 16;
  localparam int TimeW      = 22;
  localparam int QuantW     = 8;

  localparam logic [QuantW-1:0] QuantumRst = 8'd2;

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [ArrW-1:0]   arrival;
    logic [BurstW-1:0] burst;
  } job_t;

  localparam int JobW = $bits(job_t);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SORT_I,
    ST_SORT_I2,
    ST_SORT_I3,
    ST_SORT_J,
    ST_SORT_J2,
    ST_SORT_J3,
    ST_SORT_END,
    ST_ADM,
    ST_ADM2,
    ST_ADM3,
    ST_MAIN,
    ST_JUMP,
    ST_JUMP2,
    ST_JUMP3,
    ST_POP,
    ST_POP2,
    ST_POP3,
    ST_POST
  } state_e;

endpackage

FILE: rtl/rrs_ram.sv
// ----------------------------------------------------------------------------
// rrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/round_robin_scheduler_sim.sv
// ----------------------------------------------------------------------------
// round_robin_scheduler_sim
// Round-robin scheduling engine: job table load, arrival sort, queue run.
// ----------------------------------------------------------------------------
// Jobs load one beat per cycle while in_ready_o is high. The beat with
// last_job set starts a run and in_ready_o stays low until it ends. The run
// first sorts the jobs by (arrival, id) with an exchange sort through the one
// read port of the order and job RAMs, then pops slices off the queue, jumps
// the time over idle gaps to the next arrival and admits arrivals; a result
// beat may wait for out_ready_i. One result beat per job is given in
// completion order, the last one flagged by final_result_o. Beats beyond the
// table capacity are dropped but a last_job mark on them still starts the
// run.
// ----------------------------------------------------------------------------
module round_robin_scheduler_sim
  import rrs_pkg::*;
#(
  parameter int MAX_JOBS = MaxJobsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [QuantW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [IdW-1:0]    job_id_i,
  input  logic [ArrW-1:0]   arrival_time_i,
  input  logic [BurstW-1:0] burst_length_i,
  input  logic              last_job_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IdW-1:0]    done_id_o,
  output logic [TimeW-1:0]  completion_time_o,
  output logic [TimeW-1:0]  turnaround_time_o,
  output logic [TimeW-1:0]  waiting_time_o,
  output logic              final_result_o
);

  localparam int IW = $clog2(MAX_JOBS);
  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam logic [CW-1:0] MaxCnt  = CW'(MAX_JOBS);
  localparam logic [IW-1:0] LastIdx = IW'(MAX_JOBS - 1);

  state_e state_q, state_d;

  logic [QuantW-1:0] quantum_q;
  logic [CW-1:0]     loaded_q, loaded_d, finished_q, finished_d, next_q, next_d;
  logic [CW-1:0]     i_q, i_d, j_q, j_d, fill_q, fill_d;
  logic [IW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [TimeW-1:0]  time_q, time_d;
  logic [IW-1:0]     best_slot_q, best_slot_d, tmp_slot_q, tmp_slot_d;
  logic [IW-1:0]     cur_slot_q, cur_slot_d;
  job_t              best_job_q, best_job_d, cur_job_q, cur_job_d;
  logic [BurstW-1:0] rem_left_q, rem_left_d;
  logic              post_q, post_d;

  logic              out_valid_q, out_valid_d, final_q, final_d;
  logic [IdW-1:0]    done_id_q, done_id_d;
  logic [TimeW-1:0]  comp_q, comp_d, tat_q, tat_d, wt_q, wt_d;

  logic              tbl_we, rem_we, ord_we, que_we;
  logic [IW-1:0]     tbl_wa, rem_wa, ord_wa, que_wa;
  logic [IW-1:0]     tbl_ra, rem_ra, ord_ra, que_ra;
  job_t              tbl_wd, tbl_rd;
  logic [BurstW-1:0] rem_wd, rem_rd;
  logic [IW-1:0]     ord_wd, ord_rd, que_wd, que_rd;

  logic              in_acc, has_room, ahead, arr_late;
  logic [CW-1:0]     n_load;
  logic [QuantW-1:0] q_eff;
  logic [BurstW-1:0] slice;
  logic [TimeW-1:0]  tat_calc;

  rrs_ram #(.WIDTH(JobW), .DEPTH(MAX_JOBS)) u_tbl (
    .clk_i, .we_i(tbl_we), .waddr_i(tbl_wa), .wdata_i(tbl_wd),
    .raddr_i(tbl_ra), .rdata_o(tbl_rd)
  );
  rrs_ram #(.WIDTH(BurstW), .DEPTH(MAX_JOBS)) u_rem (
    .clk_i, .we_i(rem_we), .waddr_i(rem_wa), .wdata_i(rem_wd),
    .raddr_i(rem_ra), .rdata_o(rem_rd)
  );
  rrs_ram #(.WIDTH(IW), .DEPTH(MAX_JOBS)) u_ord (
    .clk_i, .we_i(ord_we), .waddr_i(ord_wa), .wdata_i(ord_wd),
    .raddr_i(ord_ra), .rdata_o(ord_rd)
  );
  rrs_ram #(.WIDTH(IW), .DEPTH(MAX_JOBS)) u_que (
    .clk_i, .we_i(que_we), .waddr_i(que_wa), .wdata_i(que_wd),
    .raddr_i(que_ra), .rdata_o(que_rd)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign has_room    = (loaded_q < MaxCnt);
  assign n_load      = has_room ? CW'(loaded_q + 1'b1) : loaded_q;
  assign ahead       = (tbl_rd.arrival < best_job_q.arrival) ||
                       ((tbl_rd.arrival == best_job_q.arrival) &&
                        (tbl_rd.id < best_job_q.id));
  assign arr_late    = ({{(TimeW-ArrW){1'b0}}, tbl_rd.arrival} > time_q);
  assign q_eff       = (quantum_q == '0) ? QuantW'(1) : quantum_q;
  assign slice       = (rem_rd < {{(BurstW-QuantW){1'b0}}, q_eff}) ? rem_rd :
                       {{(BurstW-QuantW){1'b0}}, q_eff};
  assign tat_calc    = time_q - {{(TimeW-ArrW){1'b0}}, cur_job_q.arrival};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && last_job_i) begin
          state_d = (n_load >= CW'(2)) ? ST_SORT_I : ST_ADM;
        end
      end
      ST_SORT_I:  state_d = ST_SORT_I2;
      ST_SORT_I2: state_d = ST_SORT_I3;
      ST_SORT_I3: state_d = ST_SORT_J;
      ST_SORT_J:  state_d = ST_SORT_J2;
      ST_SORT_J2: state_d = ST_SORT_J3;
      ST_SORT_J3: begin
        state_d = (CW'(j_q + 1'b1) == loaded_q) ? ST_SORT_END : ST_SORT_J;
      end
      ST_SORT_END: begin
        state_d = (CW'(i_q + 2'd2) < loaded_q) ? ST_SORT_I : ST_ADM;
      end
      ST_ADM: begin
        if (next_q < loaded_q) begin
          state_d = ST_ADM2;
        end else begin
          state_d = post_q ? ST_POST : ST_MAIN;
        end
      end
      ST_ADM2: state_d = ST_ADM3;
      ST_ADM3: begin
        if (arr_late) begin
          state_d = post_q ? ST_POST : ST_MAIN;
        end else begin
          state_d = ST_ADM;
        end
      end
      ST_MAIN: begin
        if (finished_q == loaded_q) begin
          state_d = ST_IDLE;
        end else if (fill_q != '0) begin
          state_d = ST_POP;
        end else if (next_q < loaded_q) begin
          state_d = ST_JUMP;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_JUMP:  state_d = ST_JUMP2;
      ST_JUMP2: state_d = ST_JUMP3;
      ST_JUMP3: state_d = ST_ADM;
      ST_POP:   state_d = ST_POP2;
      ST_POP2:  state_d = ST_POP3;
      ST_POP3:  state_d = ST_ADM;
      ST_POST: begin
        if (rem_left_q != '0 || !out_valid_q || out_ready_i) begin
          state_d = ST_MAIN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    loaded_d    = loaded_q;
    finished_d  = finished_q;
    next_d      = next_q;
    i_d         = i_q;
    j_d         = j_q;
    fill_d      = fill_q;
    head_d      = head_q;
    tail_d      = tail_q;
    time_d      = time_q;
    best_slot_d = best_slot_q;
    best_job_d  = best_job_q;
    tmp_slot_d  = tmp_slot_q;
    cur_slot_d  = cur_slot_q;
    cur_job_d   = cur_job_q;
    rem_left_d  = rem_left_q;
    post_d      = post_q;
    out_valid_d = out_valid_q && !out_ready_i;
    done_id_d   = done_id_q;
    comp_d      = comp_q;
    tat_d       = tat_q;
    wt_d        = wt_q;
    final_d     = final_q;

    tbl_we = 1'b0;
    tbl_wa = loaded_q[IW-1:0];
    tbl_wd = '{id: job_id_i, arrival: arrival_time_i, burst: burst_length_i};
    tbl_ra = tmp_slot_q;
    rem_we = 1'b0;
    rem_wa = loaded_q[IW-1:0];
    rem_wd = burst_length_i;
    rem_ra = que_rd;
    ord_we = 1'b0;
    ord_wa = loaded_q[IW-1:0];
    ord_wd = loaded_q[IW-1:0];
    ord_ra = next_q[IW-1:0];
    que_we = 1'b0;
    que_wa = tail_q;
    que_wd = tmp_slot_q;
    que_ra = head_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (has_room) begin
            tbl_we   = 1'b1;
            rem_we   = 1'b1;
            ord_we   = 1'b1;
            loaded_d = n_load;
          end
          i_d    = '0;
          next_d = '0;
          time_d = '0;
          post_d = 1'b0;
        end
      end
      ST_SORT_I: ord_ra = i_q[IW-1:0];
      ST_SORT_I2: begin
        best_slot_d = ord_rd;
        tbl_ra      = ord_rd;
      end
      ST_SORT_I3: begin
        best_job_d = tbl_rd;
        j_d        = CW'(i_q + 1'b1);
      end
      ST_SORT_J: ord_ra = j_q[IW-1:0];
      ST_SORT_J2: begin
        tmp_slot_d = ord_rd;
        tbl_ra     = ord_rd;
      end
      ST_SORT_J3: begin
        if (ahead) begin
          ord_we      = 1'b1;
          ord_wa      = j_q[IW-1:0];
          ord_wd      = best_slot_q;
          best_slot_d = tmp_slot_q;
          best_job_d  = tbl_rd;
        end
        j_d = CW'(j_q + 1'b1);
      end
      ST_SORT_END: begin
        ord_we = 1'b1;
        ord_wa = i_q[IW-1:0];
        ord_wd = best_slot_q;
        i_d    = CW'(i_q + 1'b1);
      end
      ST_ADM2, ST_JUMP2: begin
        tmp_slot_d = ord_rd;
        tbl_ra     = ord_rd;
      end
      ST_ADM3: begin
        if (!arr_late) begin
          que_we = 1'b1;
          tail_d = (tail_q == LastIdx) ? '0 : IW'(tail_q + 1'b1);
          fill_d = CW'(fill_q + 1'b1);
          next_d = CW'(next_q + 1'b1);
        end
      end
      ST_MAIN: begin
        if (finished_q == loaded_q || (fill_q == '0 && next_q >= loaded_q)) begin
          loaded_d   = '0;
          finished_d = '0;
          fill_d     = '0;
          head_d     = '0;
          tail_d     = '0;
        end
      end
      ST_JUMP3: begin
        time_d = {{(TimeW-ArrW){1'b0}}, tbl_rd.arrival};
        post_d = 1'b0;
      end
      ST_POP: begin
        que_ra = head_q;
        head_d = (head_q == LastIdx) ? '0 : IW'(head_q + 1'b1);
        fill_d = CW'(fill_q - 1'b1);
      end
      ST_POP2: begin
        cur_slot_d = que_rd;
        tbl_ra     = que_rd;
        rem_ra     = que_rd;
      end
      ST_POP3: begin
        cur_job_d  = tbl_rd;
        time_d     = time_q + {{(TimeW-BurstW){1'b0}}, slice};
        rem_left_d = rem_rd - slice;
        rem_we     = 1'b1;
        rem_wa     = cur_slot_q;
        rem_wd     = rem_rd - slice;
        post_d     = 1'b1;
      end
      ST_POST: begin
        if (rem_left_q != '0) begin
          que_we = 1'b1;
          que_wd = cur_slot_q;
          tail_d = (tail_q == LastIdx) ? '0 : IW'(tail_q + 1'b1);
          fill_d = CW'(fill_q + 1'b1);
        end else if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          done_id_d   = cur_job_q.id;
          comp_d      = time_q;
          tat_d       = tat_calc;
          wt_d        = tat_calc - {{(TimeW-BurstW){1'b0}}, cur_job_q.burst};
          final_d     = (CW'(finished_q + 1'b1) == loaded_q);
          finished_d  = CW'(finished_q + 1'b1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      quantum_q   <= QuantumRst;
      loaded_q    <= '0;
      finished_q  <= '0;
      next_q      <= '0;
      fill_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      time_q      <= '0;
      post_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_valid_i) begin
        quantum_q <= cfg_data_i;
      end
      loaded_q    <= loaded_d;
      finished_q  <= finished_d;
      next_q      <= next_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      time_q      <= time_d;
      post_q      <= post_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    j_q         <= j_d;
    best_slot_q <= best_slot_d;
    best_job_q  <= best_job_d;
    tmp_slot_q  <= tmp_slot_d;
    cur_slot_q  <= cur_slot_d;
    cur_job_q   <= cur_job_d;
    rem_left_q  <= rem_left_d;
    done_id_q   <= done_id_d;
    comp_q      <= comp_d;
    tat_q       <= tat_d;
    wt_q        <= wt_d;
    final_q     <= final_d;
  end

  assign out_valid_o       = out_valid_q;
  assign done_id_o         = done_id_q;
  assign completion_time_o = comp_q;
  assign turnaround_time_o = tat_q;
  assign waiting_time_o    = wt_q;
  assign final_result_o    = final_q;

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> fill_q == '0 && finished_q == '0)
    else $error("queue or finish count left over at idle");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= loaded_q)
    else $error("queue fill exceeds loaded jobs");

  a_next_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> next_q <= loaded_q && finished_q <= loaded_q)
    else $error("admit or finish count beyond loaded jobs");

  a_final_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) && final_q |=> state_q == ST_IDLE || state_q == ST_MAIN)
    else $error("run continues after final result");

endmodule

FILE: bench/round_robin_scheduler_sim_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_scheduler_sim_tb
// Job sets are streamed into the scheduler under several quantum settings and
// idle patterns. A built-in round-robin predictor computes every completion
// beat, and the monitor compares each result beat field by field.
// ----------------------------------------------------------------------------
module round_robin_scheduler_sim_tb;
  import rrs_pkg::*;

  localparam int NJobs     = MaxJobsDef;
  localparam int TimeMask  = 32'h3F_FFFF;
  localparam int CycleLim  = 2_000_000;

  typedef struct {
    logic [IdW-1:0]    id;
    logic [ArrW-1:0]   arr;
    logic [BurstW-1:0] bur;
    logic              last;
    logic              hold;
  } job_item_t;

  typedef struct {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] ct;
    logic [TimeW-1:0] tat;
    logic [TimeW-1:0] wt;
    logic             fin;
  } done_beat_t;

  logic              clk_i, rst_ni;
  logic              cfg_valid_i, cfg_ready_o;
  logic [QuantW-1:0] cfg_data_i;
  logic              in_valid_i, in_ready_o;
  logic [IdW-1:0]    job_id_i;
  logic [ArrW-1:0]   arrival_time_i;
  logic [BurstW-1:0] burst_length_i;
  logic              last_job_i;
  logic              out_valid_o, out_ready_i;
  logic [IdW-1:0]    done_id_o;
  logic [TimeW-1:0]  completion_time_o, turnaround_time_o, waiting_time_o;
  logic              final_result_o;

  round_robin_scheduler_sim dut (.*);

  job_item_t  job_q[$];
  done_beat_t done_q[$];
  int send_idle, recv_idle, fails, cycles;
  int quantum;
  int ld_n;
  logic [IdW-1:0]    tb_id [NJobs];
  logic [ArrW-1:0]   tb_arr[NJobs];
  logic [BurstW-1:0] tb_bur[NJobs];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit runs_first(int a, int b);
    if (tb_arr[a] != tb_arr[b]) return tb_arr[a] < tb_arr[b];
    return tb_id[a] < tb_id[b];
  endfunction

  task automatic schedule_set(int n);
    int ord[NJobs];
    int rem[NJobs];
    bit qd[NJobs];
    int rq[$];
    int t, nx, fin, q, slot, slice, tmp, tat;
    done_beat_t b;
    q = (quantum == 0) ? 1 : quantum;
    for (int i = 0; i < n; i++) begin
      ord[i] = i;
      rem[i] = tb_bur[i];
      qd[i] = 1'b0;
    end
    for (int i = 0; i + 1 < n; i++)
      for (int j = i + 1; j < n; j++)
        if (runs_first(ord[j], ord[i])) begin
          tmp = ord[i]; ord[i] = ord[j]; ord[j] = tmp;
        end
    t = 0; nx = 0; fin = 0;
    slot = -1; slice = -1;
    while (nx < n && tb_arr[ord[nx]] <= t) begin
      if (!qd[ord[nx]]) begin rq.push_back(ord[nx]); qd[ord[nx]] = 1'b1; end
      nx++;
    end
    while (fin < n) begin
      if (rq.size() == 0) begin
        if (nx >= n) break;
        t = tb_arr[ord[nx]];
      end else begin
        slot = rq.pop_front();
        slice = (rem[slot] < q) ? rem[slot] : q;
        t = (t + slice) & TimeMask;
        rem[slot] -= slice;
      end
      while (nx < n && tb_arr[ord[nx]] <= t) begin
        if (!qd[ord[nx]]) begin rq.push_back(ord[nx]); qd[ord[nx]] = 1'b1; end
        nx++;
      end
      if (slice >= 0 && slot >= 0) begin
        if (rem[slot] > 0) rq.push_back(slot);
        else begin
          fin++;
          tat = (t - tb_arr[slot]) & TimeMask;
          b.id = tb_id[slot];
          b.ct = TimeW'(t);
          b.tat = TimeW'(tat);
          b.wt = TimeW'((tat - tb_bur[slot]) & TimeMask);
          b.fin = (fin == n);
          done_q.push_back(b);
        end
      end
      slot = -1; slice = -1;
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      job_id_i       <= '0;
      arrival_time_i <= '0;
      burst_length_i <= '0;
      last_job_i     <= 1'b0;
      ld_n = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (ld_n < NJobs) begin
          tb_id[ld_n] = job_id_i;
          tb_arr[ld_n] = arrival_time_i;
          tb_bur[ld_n] = burst_length_i;
          ld_n++;
        end
        if (last_job_i) begin
          schedule_set(ld_n);
          ld_n = 0;
        end
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (job_q.size() > 0 && $urandom_range(99) >= send_idle &&
            !(job_q[0].hold && done_q.size() > 0)) begin
          in_valid_i     <= 1'b1;
          job_id_i       <= job_q[0].id;
          arrival_time_i <= job_q[0].arr;
          burst_length_i <= job_q[0].bur;
          last_job_i     <= job_q[0].last;
          void'(job_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
      if (out_valid_o && out_ready_i) begin
        if (done_q.size() == 0) begin
          $error("unexpected result beat id=%0d", done_id_o);
          fails++;
        end else begin
          done_beat_t e;
          e = done_q.pop_front();
          if (done_id_o !== e.id) begin
            $error("done_id exp %0d got %0d", e.id, done_id_o); fails++;
          end
          if (completion_time_o !== e.ct) begin
            $error("completion_time exp %0d got %0d", e.ct, completion_time_o); fails++;
          end
          if (turnaround_time_o !== e.tat) begin
            $error("turnaround_time exp %0d got %0d", e.tat, turnaround_time_o); fails++;
          end
          if (waiting_time_o !== e.wt) begin
            $error("waiting_time exp %0d got %0d", e.wt, waiting_time_o); fails++;
          end
          if (final_result_o !== e.fin) begin
            $error("final_result exp %0d got %0d", e.fin, final_result_o); fails++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLim) begin
      $display("round_robin_scheduler_sim: mismatch");
      $finish;
    end
  end

  task automatic add_job(int id, int arr, int bur, bit last, bit hold = 1'b0);
    job_item_t it;
    it.id = IdW'(id); it.arr = ArrW'(arr); it.bur = BurstW'(bur);
    it.last = last; it.hold = hold;
    job_q.push_back(it);
  endtask

  task automatic write_quantum(int v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= QuantW'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
    quantum = v & 8'hFF;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain;
    while (job_q.size() > 0 || in_valid_i || done_q.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic random_sets(int total);
    int cnt, n, bur;
    cnt = 0;
    while (cnt < total) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        if (quantum >= 128 && $urandom_range(15) == 0) bur = $urandom_range(65535);
        else bur = $urandom_range(20);
        add_job($urandom_range(255),
                ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(40),
                bur, i == n - 1, i == 0 && $urandom_range(20) == 0);
      end
      cnt += n;
    end
  endtask

  initial begin
    int qlist[6];
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_data_i = '0;
    quantum = QuantumRst;
    send_idle = 30; recv_idle = 86;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero burst, ties on arrival, equal ids, gaps in arrival
    add_job(0, 0, 0, 1'b1);
    add_job(5, 3, 4, 1'b0);
    add_job(2, 3, 1, 1'b0);
    add_job(9, 0, 5, 1'b1);
    add_job(7, 10, 3, 1'b0, 1'b1);
    add_job(7, 10, 2, 1'b0);
    add_job(1, 100, 0, 1'b0);
    add_job(4, 200, 7, 1'b1);
    drain();
    write_quantum(255);
    add_job(255, 65535, 65535, 1'b0, 1'b1);
    add_job(0, 0, 65535, 1'b1);
    drain();
    write_quantum(0);
    add_job(3, 1, 3, 1'b0);
    add_job(8, 0, 2, 1'b1);
    drain();

    qlist = '{1, 255, 2, 0, 128 + $urandom_range(127), $urandom_range(1, 255)};
    for (int p = 0; p < 6; p++) begin
      write_quantum(qlist[p]);
      case (p % 3)
        0: begin send_idle = 30; recv_idle = 86; end
        1: begin send_idle = 86; recv_idle = 30; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      random_sets(68);
      drain();
    end

    if (fails == 0 && done_q.size() == 0)
      $display("round_robin_scheduler_sim: match");
    else
      $display("round_robin_scheduler_sim: mismatch");
    $finish;
  end
endmodule

FILE: files.f
rtl/rrs_pkg.sv
rtl/rrs_ram.sv
rtl/round_robin_scheduler_sim.sv
bench/round_robin_scheduler_sim_tb.sv
